// ===== src/cpsm_pkg.sv =====
// ----------------------------------------------------------------------------
// cpsm_pkg
// Shared types and constants for the conservative pointer scan marker.
// ----------------------------------------------------------------------------
package cpsm_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 1024;
  localparam int WORD_W              = 64;
  localparam int OP_W                = 2;
  localparam int STATUS_W            = 3;
  localparam int INDEX_OUT_W         = 10;

  localparam logic [WORD_W-1:0] ADDR_MASK = ~(WORD_W'(3));

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_SCAN   = 2'd1,
    OP_RETIRE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_ORDER = 3'd2,
    ST_EMPTY = 3'd3,
    ST_DRAIN = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_RETIRE,
    S_FINISH
  } state_t;

  typedef struct packed {
    status_t                  status;
    logic                     hit;
    logic [INDEX_OUT_W-1:0]   entry_index;
    logic [WORD_W-1:0]        entry_address;
    logic                     referenced;
    logic                     last;
  } result_t;

endpackage

// ===== src/cpsm_req_if.sv =====
// ----------------------------------------------------------------------------
// cpsm_req_if
// Request channel: operation code and word, valid/ready transfer.
// ----------------------------------------------------------------------------
interface cpsm_req_if import cpsm_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [WORD_W-1:0] word;

  modport source (output valid, output operation, output word, input ready);
  modport sink   (input valid, input operation, input word, output ready);

endinterface

// ===== src/cpsm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cpsm_rsp_if
// Response channel: one result per request, valid/ready transfer.
// ----------------------------------------------------------------------------
interface cpsm_rsp_if import cpsm_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic                   hit;
  logic [INDEX_OUT_W-1:0] entry_index;
  logic [WORD_W-1:0]      entry_address;
  logic                   referenced;
  logic                   last;

  modport source (output valid, output status, output hit, output entry_index,
                  output entry_address, output referenced, output last,
                  input ready);
  modport sink   (input valid, input status, input hit, input entry_index,
                  input entry_address, input referenced, input last,
                  output ready);

endinterface

// ===== src/cpsm_ram.sv =====
// ----------------------------------------------------------------------------
// cpsm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cpsm_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/conservative_pointer_scan_marker.sv =====
// ----------------------------------------------------------------------------
// conservative_pointer_scan_marker
// Ascending address table with mark bits: load, scan by binary search, retire.
// A load, a refusal or an out-of-range scan goes from S_IDLE to S_FINISH;
// a retire passes through S_RETIRE, a scan in range through S_SEARCH,
// with one table RAM read and compare per binary search step.
// One item at a time; ready returns once the result is handed to the output.
// Reset empties the table and drain position; table RAM needs no clearing.
// ----------------------------------------------------------------------------
module conservative_pointer_scan_marker import cpsm_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  cpsm_req_if.sink    req,
  cpsm_rsp_if.source  rsp
);

  localparam int IW    = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int RAM_W = WORD_W + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  function automatic logic [INDEX_OUT_W-1:0] index_out(input logic [IW-1:0] i);
    logic [IW+INDEX_OUT_W-1:0] w;
    w = {{INDEX_OUT_W{1'b0}}, i};
    return w[INDEX_OUT_W-1:0];
  endfunction

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [IW-1:0]     rpos, rpos_next;
  logic [WORD_W-1:0] first_addr, first_addr_next;
  logic [WORD_W-1:0] last_addr, last_addr_next;
  logic [WORD_W-1:0] key, key_next;
  logic [CW-1:0]     lo, lo_next;
  logic [CW-1:0]     hi, hi_next;
  logic [IW-1:0]     mid, mid_next;
  result_t           res, res_next;
  logic              rsp_valid, rsp_valid_next;
  result_t           rsp_data, rsp_data_next;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [RAM_W-1:0]  ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [RAM_W-1:0]  ram_rdata;

  logic [WORD_W-1:0] scan_key;
  logic [WORD_W-1:0] prev_addr;
  logic [CW-1:0]     half_count;
  logic [CW-1:0]     count_m1;
  logic [CW-1:0]     rpos_ext;
  logic [CW-1:0]     mid_ext;
  logic [CW-1:0]     lo_n, hi_n, mid_n;
  logic [IW-1:0]     pos;
  logic [WORD_W-1:0] entry_val;

  cpsm_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign scan_key   = req.word & ADDR_MASK;
  assign prev_addr  = (count == '0) ? '0 : last_addr;
  assign half_count = count >> 1;
  assign count_m1   = count - CW'(1);
  assign rpos_ext   = CW'(rpos);
  assign mid_ext    = CW'(mid);
  assign pos        = (rpos_ext >= count) ? count_m1[IW-1:0] : rpos;
  assign entry_val  = ram_rdata[WORD_W-1:0];

  always_comb begin
    state_next      = state;
    count_next      = count;
    rpos_next       = rpos;
    first_addr_next = first_addr;
    last_addr_next  = last_addr;
    key_next        = key;
    lo_next         = lo;
    hi_next         = hi;
    mid_next        = mid;
    res_next        = res;
    rsp_valid_next  = rsp_valid && !rsp.ready;
    rsp_data_next   = rsp_data;
    ram_we          = 1'b0;
    ram_waddr       = count[IW-1:0];
    ram_wdata       = {1'b0, req.word};
    ram_raddr       = mid;
    lo_n            = lo;
    hi_n            = hi;
    mid_n           = mid_ext;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          res_next   = '0;
          state_next = S_FINISH;
          case (op_t'(req.operation))
            OP_LOAD: begin
              if (rpos != '0) begin
                res_next.status = ST_DRAIN;
              end else if (count >= DEPTH_C) begin
                res_next.status = ST_FULL;
              end else if (req.word[1:0] != 2'b00 || req.word <= prev_addr) begin
                res_next.status = ST_ORDER;
              end else begin
                ram_we               = 1'b1;
                res_next.entry_index = index_out(count[IW-1:0]);
                last_addr_next       = req.word;
                if (count == '0) begin
                  first_addr_next = req.word;
                end
                count_next = count + CW'(1);
              end
            end
            OP_SCAN: begin
              key_next = scan_key;
              if (count == '0) begin
                res_next.status = ST_EMPTY;
              end else if (rpos != '0) begin
                res_next.status = ST_DRAIN;
              end else if (scan_key >= first_addr && scan_key <= last_addr) begin
                lo_next    = '0;
                hi_next    = count;
                mid_next   = half_count[IW-1:0];
                ram_raddr  = half_count[IW-1:0];
                state_next = S_SEARCH;
              end
            end
            OP_RETIRE: begin
              if (count == '0) begin
                res_next.status = ST_EMPTY;
              end else begin
                mid_next   = pos;
                ram_raddr  = pos;
                state_next = S_RETIRE;
              end
            end
            default: begin
              res_next = '0;
            end
          endcase
        end
      end

      S_SEARCH: begin
        if (entry_val == key) begin
          ram_we               = 1'b1;
          ram_waddr            = mid;
          ram_wdata            = {1'b1, key};
          res_next.hit         = 1'b1;
          res_next.entry_index = index_out(mid);
          state_next           = S_FINISH;
        end else begin
          if (entry_val < key) begin
            lo_n = mid_ext + CW'(1);
          end else begin
            hi_n = mid_ext;
          end
          lo_next = lo_n;
          hi_next = hi_n;
          if (lo_n < hi_n) begin
            mid_n     = lo_n + ((hi_n - lo_n) >> 1);
            mid_next  = mid_n[IW-1:0];
            ram_raddr = mid_n[IW-1:0];
          end else begin
            state_next = S_FINISH;
          end
        end
      end

      S_RETIRE: begin
        res_next.entry_index   = index_out(mid);
        res_next.entry_address = entry_val;
        res_next.referenced    = ram_rdata[WORD_W];
        res_next.last          = (mid_ext == count_m1);
        if (mid_ext == count_m1) begin
          count_next = '0;
          rpos_next  = '0;
        end else begin
          rpos_next = mid + IW'(1);
        end
        state_next = S_FINISH;
      end

      S_FINISH: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_valid_next = 1'b1;
          rsp_data_next  = res;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rpos      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rpos      <= rpos_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    first_addr <= first_addr_next;
    last_addr  <= last_addr_next;
    key        <= key_next;
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    res        <= res_next;
    rsp_data   <= rsp_data_next;
  end

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_data.status;
  assign rsp.hit           = rsp_data.hit;
  assign rsp.entry_index   = rsp_data.entry_index;
  assign rsp.entry_address = rsp_data.entry_address;
  assign rsp.referenced    = rsp_data.referenced;
  assign rsp.last          = rsp_data.last;

endmodule
